/* rtl/mmsm_pkg.sv */
`default_nettype none

package mmsm_pkg;

    localparam int unsigned ACTION_W = 4;
    localparam int unsigned STATE_W  = 4;
    localparam int unsigned EVENT_W  = 3;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned TIME_W   = 32;

    // motion states
    typedef enum logic [STATE_W-1:0] {
        ST_DISABLED  = 4'd0,
        ST_IDLE      = 4'd1,
        ST_WAITSTART = 4'd2,
        ST_STARTING  = 4'd3,
        ST_RUNFWD    = 4'd4,
        ST_RUNBACK   = 4'd5,
        ST_DECEL     = 4'd6,
        ST_TARGET    = 4'd7,
        ST_LIMIT     = 4'd8,
        ST_STALL     = 4'd9,
        ST_FAULT     = 4'd10
    } t_state;

    // event types
    typedef enum logic [EVENT_W-1:0] {
        EV_CHANGED = 3'd0,
        EV_STOPPED = 3'd1,
        EV_STARTED = 3'd2,
        EV_TARGET  = 3'd3,
        EV_LIMIT   = 3'd4,
        EV_STALL   = 3'd5,
        EV_FAULT   = 3'd6
    } t_event;

    // request codes, all sixteen are meaningful
    typedef enum logic [ACTION_W-1:0] {
        ACT_ENABLE    = 4'd0,
        ACT_DISABLE   = 4'd1,
        ACT_FWD       = 4'd2,
        ACT_BACK      = 4'd3,
        ACT_WAITSTART = 4'd4,
        ACT_STARTING  = 4'd5,
        ACT_RUNNING   = 4'd6,
        ACT_DECEL     = 4'd7,
        ACT_STOP      = 4'd8,
        ACT_ESTOP     = 4'd9,
        ACT_TARGET    = 4'd10,
        ACT_LIMIT     = 4'd11,
        ACT_STALL     = 4'd12,
        ACT_FAULT     = 4'd13,
        ACT_CLRSTALL  = 4'd14,
        ACT_CLRFAULT  = 4'd15
    } t_action;

endpackage

`default_nettype wire

/* rtl/mmsm_req_if.sv */
`default_nettype none

interface mmsm_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [mmsm_pkg::ACTION_W-1:0]        action;
    logic                                 direction;
    logic signed [mmsm_pkg::POS_W-1:0]    position;
    logic [mmsm_pkg::TIME_W-1:0]          timestamp_ms;

    modport source (output valid, action, direction, position, timestamp_ms, input ready);
    modport sink   (input valid, action, direction, position, timestamp_ms, output ready);
endinterface

`default_nettype wire

/* rtl/mmsm_evt_if.sv */
`default_nettype none

interface mmsm_evt_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 accepted;
    logic [mmsm_pkg::EVENT_W-1:0]         event_type;
    logic [mmsm_pkg::STATE_W-1:0]         previous_state;
    logic [mmsm_pkg::STATE_W-1:0]         new_state;
    logic signed [mmsm_pkg::POS_W-1:0]    event_position;
    logic [mmsm_pkg::TIME_W-1:0]          event_time;

    modport source (output valid, accepted, event_type, previous_state, new_state,
                    event_position, event_time, input ready);
    modport sink   (input valid, accepted, event_type, previous_state, new_state,
                    event_position, event_time, output ready);
endinterface

`default_nettype wire

/* rtl/motor_motion_state_machine.sv */
`default_nettype none

// channel   dir   modport  payload
// i_req     in    sink     action, direction, position, timestamp_ms
// o_evt     out   source   accepted, event_type, previous_state, new_state,
//                          event_position, event_time
//
// one item per cycle unless o_evt stalls; each result follows in the next cycle
// the guard table is evaluated on the motion state register at the request edge,
// and the state and the result register load together
// the request side is ready whenever the result register is empty or being drained
// synchronous active-low reset puts the block in the disabled state, no result pending

module motor_motion_state_machine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mmsm_req_if.sink    i_req,
    mmsm_evt_if.source  o_evt
);

    mmsm_pkg::t_state  r_state;
    mmsm_pkg::t_state  n_state;
    mmsm_pkg::t_event  n_event;
    logic              n_ok;
    logic              w_moving;
    logic              w_req_take;

    logic                                r_out_valid;
    logic                                r_accepted;
    logic [mmsm_pkg::EVENT_W-1:0]        r_event_type;
    logic [mmsm_pkg::STATE_W-1:0]        r_prev_state;
    logic [mmsm_pkg::STATE_W-1:0]        r_new_state;
    logic signed [mmsm_pkg::POS_W-1:0]   r_event_position;
    logic [mmsm_pkg::TIME_W-1:0]         r_event_time;

    // result register frees up in the same cycle it is taken
    assign i_req.ready = !r_out_valid || o_evt.ready;
    assign w_req_take  = i_req.valid && i_req.ready;

    // waitstart through decelerating count as moving
    assign w_moving = (r_state >= mmsm_pkg::ST_WAITSTART) &&
                      (r_state <= mmsm_pkg::ST_DECEL);

    // guarded transition table
    always_comb begin
        n_ok    = 1'b0;
        n_state = r_state;
        n_event = mmsm_pkg::EV_CHANGED;
        unique case (mmsm_pkg::t_action'(i_req.action))
            mmsm_pkg::ACT_ENABLE: begin
                if (r_state == mmsm_pkg::ST_DISABLED) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_IDLE;
                end
            end
            mmsm_pkg::ACT_DISABLE: begin
                // always legal, even when already disabled
                n_ok = 1'b1; n_state = mmsm_pkg::ST_DISABLED; n_event = mmsm_pkg::EV_STOPPED;
            end
            mmsm_pkg::ACT_FWD, mmsm_pkg::ACT_BACK: begin
                if (r_state == mmsm_pkg::ST_IDLE) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_STARTING;
                    n_event = mmsm_pkg::EV_STARTED;
                end
            end
            mmsm_pkg::ACT_WAITSTART: begin
                if (r_state == mmsm_pkg::ST_IDLE) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_WAITSTART;
                end
            end
            mmsm_pkg::ACT_STARTING: begin
                if (r_state == mmsm_pkg::ST_IDLE || r_state == mmsm_pkg::ST_WAITSTART) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_STARTING;
                    n_event = mmsm_pkg::EV_STARTED;
                end
            end
            mmsm_pkg::ACT_RUNNING: begin
                if (r_state == mmsm_pkg::ST_STARTING) begin
                    n_ok    = 1'b1;
                    n_state = i_req.direction ? mmsm_pkg::ST_RUNBACK : mmsm_pkg::ST_RUNFWD;
                end
            end
            mmsm_pkg::ACT_DECEL: begin
                if (w_moving) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_DECEL;
                end
            end
            mmsm_pkg::ACT_STOP: begin
                // stop while moving reports stopped, from target or limit just changed
                if (w_moving) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_IDLE; n_event = mmsm_pkg::EV_STOPPED;
                end else if (r_state == mmsm_pkg::ST_TARGET ||
                             r_state == mmsm_pkg::ST_LIMIT) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_IDLE;
                end
            end
            mmsm_pkg::ACT_ESTOP: begin
                if (r_state != mmsm_pkg::ST_DISABLED) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_IDLE; n_event = mmsm_pkg::EV_STOPPED;
                end
            end
            mmsm_pkg::ACT_TARGET: begin
                if (w_moving) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_TARGET; n_event = mmsm_pkg::EV_TARGET;
                end
            end
            mmsm_pkg::ACT_LIMIT: begin
                if (w_moving) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_LIMIT; n_event = mmsm_pkg::EV_LIMIT;
                end
            end
            mmsm_pkg::ACT_STALL: begin
                if (w_moving) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_STALL; n_event = mmsm_pkg::EV_STALL;
                end
            end
            mmsm_pkg::ACT_FAULT: begin
                // includes re-entering fault from fault
                if (r_state != mmsm_pkg::ST_DISABLED) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_FAULT; n_event = mmsm_pkg::EV_FAULT;
                end
            end
            mmsm_pkg::ACT_CLRSTALL: begin
                if (r_state == mmsm_pkg::ST_STALL) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_IDLE;
                end
            end
            mmsm_pkg::ACT_CLRFAULT: begin
                if (r_state == mmsm_pkg::ST_FAULT) begin
                    n_ok = 1'b1; n_state = mmsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmsm_pkg::ST_DISABLED;
            r_out_valid <= 1'b0;
        end else begin
            if (w_req_take && n_ok) begin
                r_state <= n_state;
            end
            if (w_req_take) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, all zero on a rejected request
    always_ff @(posedge i_clk) begin
        if (w_req_take) begin
            r_accepted <= n_ok;
            if (n_ok) begin
                r_event_type     <= n_event;
                r_prev_state     <= r_state;
                r_new_state      <= n_state;
                r_event_position <= i_req.position;
                r_event_time     <= i_req.timestamp_ms;
            end else begin
                r_event_type     <= '0;
                r_prev_state     <= '0;
                r_new_state      <= '0;
                r_event_position <= '0;
                r_event_time     <= '0;
            end
        end
    end

    assign o_evt.valid          = r_out_valid;
    assign o_evt.accepted       = r_accepted;
    assign o_evt.event_type     = r_event_type;
    assign o_evt.previous_state = r_prev_state;
    assign o_evt.new_state      = r_new_state;
    assign o_evt.event_position = r_event_position;
    assign o_evt.event_time     = r_event_time;

    // state never leaves the defined range
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= mmsm_pkg::ST_FAULT)
        else $error("motion state out of range");

    // a freshly loaded accepted result matches the state register
    a_state_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_req_take) && r_out_valid && r_accepted |-> r_new_state == r_state)
        else $error("result new state differs from motion state");

    // a rejected request leaves the state alone
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_take && !n_ok |=> $stable(r_state))
        else $error("rejected request changed state");

    // from disabled only enable or disable can be accepted
    a_leave_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_accepted && r_prev_state == mmsm_pkg::ST_DISABLED
        |-> r_new_state == mmsm_pkg::ST_IDLE || r_new_state == mmsm_pkg::ST_DISABLED)
        else $error("illegal exit from disabled");

endmodule

`default_nettype wire
